FILE: rtl/lru_merged_texture_cache_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the texture cache tag store checkers.
// ----------------------------------------------------------------------------
`ifndef LRU_MERGED_TEXTURE_CACHE_MACROS_SVH
`define LRU_MERGED_TEXTURE_CACHE_MACROS_SVH

// Plain property, clocked on the rising edge and disabled in reset.
`define LMTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lmtc assertion failed");

// Overlapping implication built on the plain form.
`define LMTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    `LMTC_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

// Non-overlapping implication built on the plain form.
`define LMTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    `LMTC_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

FILE: rtl/lmtc_pkg.sv
// ----------------------------------------------------------------------------
// lmtc_pkg
// Types, constants and codes shared by the texture cache tag store.
// ----------------------------------------------------------------------------
package lmtc_pkg;

    localparam int ENTRIES_DEF = 128;
    localparam int ID_BITS_DEF = 16;

    localparam int TEX_W      = 16;
    localparam int ORIENT_W   = 2;
    localparam int FRAME_W    = 31;
    localparam int SLOT_W     = 7;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_REG_W  = 8;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic               empty;
        logic [FRAME_W-1:0] frame;
    } t_stamp;

    localparam int STAMP_W = $bits(t_stamp);

    localparam t_stamp STAMP_EMPTY = '{empty: 1'b1, frame: '1};

    typedef struct packed {
        logic match;
        logic lower;
    } t_cmp_res;

endpackage

FILE: rtl/lmtc_ram.sv
// ----------------------------------------------------------------------------
// lmtc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lmtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lmtc_cmp.sv
// ----------------------------------------------------------------------------
// lmtc_cmp
// Shared compare unit: key match against one entry and stamp ordering.
// ----------------------------------------------------------------------------
module lmtc_cmp import lmtc_pkg::*; #(
    parameter int KEY_W = 2 * ID_BITS_DEF + ORIENT_W
) (
    input  logic [KEY_W-1:0] i_entry_key,
    input  t_stamp           i_entry_stamp,
    input  logic [KEY_W-1:0] i_key,
    input  t_stamp           i_lowest,
    output t_cmp_res         o_res
);

    // An empty stamp stands for minus one, below every frame number.
    always_comb begin
        o_res.match = !i_entry_stamp.empty && (i_entry_key == i_key);
        if (i_entry_stamp.empty) begin
            o_res.lower = !i_lowest.empty;
        end else begin
            o_res.lower = !i_lowest.empty && (i_entry_stamp.frame < i_lowest.frame);
        end
    end

endmodule

FILE: rtl/lru_merged_texture_cache.sv
// ----------------------------------------------------------------------------
// lru_merged_texture_cache
// Fully associative tag store with frame-stamped least-recently-used
// replacement for merged textures.
// ----------------------------------------------------------------------------
// A lookup walks the first entries_in_use entries through one compare unit,
// one entry per cycle from the read port of the tag and stamp RAMs, and it
// stops early on a hit. A flush rewrites every stamp, one entry a cycle.
// After reset the same clearing pass runs over every entry before the first
// input beat is taken. One item is in flight at a time; the next input beat
// is taken while a result beat still waits in the output register.
module lru_merged_texture_cache import lmtc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [TEX_W-1:0]      i_bottom_texture,
    input  logic [TEX_W-1:0]      i_top_texture,
    input  logic [ORIENT_W-1:0]   i_orient,
    input  logic [FRAME_W-1:0]    i_frame_number,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [COUNT_W-1:0]    o_hit_count,
    output logic [COUNT_W-1:0]    o_miss_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = 2 * ID_BITS + ORIENT_W;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_scan_len;
    logic [IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic                r_flush, n_flush;
    logic [CNT_W-1:0]    r_rd_cnt, n_rd_cnt;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    t_stamp              r_lowest, n_lowest;
    logic [IDX_W-1:0]    r_lru, n_lru;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [COUNT_W-1:0]  r_hits, n_hits;
    logic [COUNT_W-1:0]  r_misses, n_misses;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]  r_out_hits, n_out_hits;
    logic [COUNT_W-1:0]  r_out_misses, n_out_misses;

    logic                stamp_we;
    logic [IDX_W-1:0]    stamp_waddr;
    t_stamp              stamp_wdata;
    t_stamp              stamp_rdata;
    logic                key_we;
    logic [KEY_W-1:0]    key_rdata;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    t_cmp_res            cmp_res;
    logic                cfg_write;
    logic [CFG_REG_W-1:0] cfg_value;
    logic                pend_last;
    logic [IDX_W-1:0]    lru_pick;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_value = pwdata[CFG_REG_W-1:0];
    assign prdata    = CFG_DATA_W'(r_scan_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_len <= CNT_W'(ENTRIES);
        end else if (cfg_write) begin
            if (cfg_value == '0 || 32'(cfg_value) > 32'(ENTRIES)) begin
                r_scan_len <= CNT_W'(ENTRIES);
            end else begin
                r_scan_len <= CNT_W'(cfg_value);
            end
        end
    end

    lmtc_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (ENTRIES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (stamp_rdata)
    );

    lmtc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    lmtc_cmp #(
        .KEY_W (KEY_W)
    ) u_cmp (
        .i_entry_key   (key_rdata),
        .i_entry_stamp (stamp_rdata),
        .i_key         (r_key),
        .i_lowest      (r_lowest),
        .o_res         (cmp_res)
    );

    assign pend_last = (CNT_W'(r_pend_idx) + CNT_W'(1)) == r_scan_len;
    assign lru_pick  = (r_pend_idx == '0 || cmp_res.lower) ? r_pend_idx : r_lru;

    assign rd_addr = r_rd_cnt[IDX_W-1:0];

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_slot       = r_out_slot;
    assign o_hit_count  = r_out_hits;
    assign o_miss_count = r_out_misses;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_flush      = r_flush;
        n_rd_cnt     = r_rd_cnt;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_key        = r_key;
        n_frame      = r_frame;
        n_lowest     = r_lowest;
        n_lru        = r_lru;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_hit    = r_out_hit;
        n_out_slot   = r_out_slot;
        n_out_hits   = r_out_hits;
        n_out_misses = r_out_misses;
        stamp_we     = 1'b0;
        stamp_waddr  = r_slot;
        stamp_wdata  = '{empty: 1'b0, frame: r_frame};
        key_we       = 1'b0;
        rd_en        = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                stamp_we    = 1'b1;
                stamp_waddr = r_clr_idx;
                stamp_wdata = STAMP_EMPTY;
                n_clr_idx   = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(ENTRIES - 1)) begin
                    n_clr_idx = '0;
                    n_state   = r_flush ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key    = {ID_BITS'(i_bottom_texture), ID_BITS'(i_top_texture),
                                i_orient};
                    n_frame  = i_frame_number;
                    n_hit    = 1'b0;
                    n_slot   = '0;
                    n_rd_cnt = '0;
                    if (t_cmd'(i_cmd) == CMD_FLUSH) begin
                        n_flush = 1'b1;
                        n_state = ST_CLEAR;
                    end else begin
                        n_flush = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_cnt < r_scan_len) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_cnt[IDX_W-1:0];
                    n_rd_cnt   = r_rd_cnt + CNT_W'(1);
                end
                if (r_pend) begin
                    if (cmp_res.match) begin
                        n_hit   = 1'b1;
                        n_slot  = r_pend_idx;
                        n_state = ST_UPDATE;
                    end else begin
                        if (r_pend_idx == '0 || cmp_res.lower) begin
                            n_lowest = stamp_rdata;
                        end
                        n_lru = lru_pick;
                        if (pend_last) begin
                            n_slot  = lru_pick;
                            n_state = ST_UPDATE;
                        end
                    end
                end
            end
            ST_UPDATE: begin
                stamp_we = 1'b1;
                key_we   = !r_hit;
                if (r_hit) begin
                    n_hits = r_hits + COUNT_W'(1);
                end else begin
                    n_misses = r_misses + COUNT_W'(1);
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = r_hit;
                    n_out_slot   = SLOT_W'(r_slot);
                    n_out_hits   = r_hits;
                    n_out_misses = r_misses;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_flush     <= 1'b0;
            r_pend      <= 1'b0;
            r_rd_cnt    <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_idx   <= n_clr_idx;
            r_flush     <= n_flush;
            r_pend      <= n_pend;
            r_rd_cnt    <= n_rd_cnt;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_key        <= n_key;
        r_frame      <= n_frame;
        r_lowest     <= n_lowest;
        r_lru        <= n_lru;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_out_hit    <= n_out_hit;
        r_out_slot   <= n_out_slot;
        r_out_hits   <= n_out_hits;
        r_out_misses <= n_out_misses;
    end

endmodule

FILE: rtl/lmtc_chk.sv
// ----------------------------------------------------------------------------
// lmtc_chk
// Port-level checker for the texture cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_merged_texture_cache_macros.svh"

module lmtc_chk import lmtc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input logic               i_hit,
    input logic [SLOT_W-1:0]  i_slot,
    input logic [COUNT_W-1:0] i_hit_count,
    input logic [COUNT_W-1:0] i_miss_count
);

    // A stalled result beat keeps its payload.
    `LMTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_hit) && $stable(i_slot) && $stable(i_hit_count) && $stable(i_miss_count))

    // Only one item is in flight: an input beat closes the input side.
    `LMTC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    // A result beat only appears out of a busy block.
    `LMTC_ASSERT_IMPL(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_stall))

endmodule

bind lru_merged_texture_cache lmtc_chk u_lmtc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_hit        (o_hit),
    .i_slot       (o_slot),
    .i_hit_count  (o_hit_count),
    .i_miss_count (o_miss_count)
);
